### rtl/pskt_pkg.sv
// pskt_pkg: shared types and codes for the parent-sorted key table.
// No dependencies; used by pskt_cmp, pskt_mem and parent_sorted_key_table_top.
package pskt_pkg;

    localparam int KEY_W = 32;
    localparam int CMD_W = 3;
    localparam int ST_W  = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO_KEY = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_HAS_KIDS = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] parent;
        logic [KEY_W-1:0] payload;
    } t_entry;

    // flags from the shared compare unit
    typedef struct packed {
        logic key_eq;   // entry key equals operand key
        logic par_eq;   // entry parent equals operand parent
        logic par_gt;   // entry parent above operand parent
        logic child;    // entry parent equals operand key
    } t_cmp;

endpackage

### rtl/pskt_cmp.sv
// pskt_cmp: shared compare unit, applied to one table entry per cycle unless a list scan is held.
// Depends on pskt_pkg.
module pskt_cmp
    import pskt_pkg::*;
(
    input  t_entry           i_ent,
    input  logic [KEY_W-1:0] i_key,
    input  logic [KEY_W-1:0] i_par,
    output t_cmp             o_flags
);

    assign o_flags.key_eq = (i_ent.key == i_key);
    assign o_flags.par_eq = (i_ent.parent == i_par);
    assign o_flags.par_gt = (i_ent.parent > i_par);
    assign o_flags.child  = (i_ent.parent == i_key);

endmodule

### rtl/pskt_mem.sv
// pskt_mem: entry store, one write port and one registered read port.
// Depends on pskt_pkg.
module pskt_mem
    import pskt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/parent_sorted_key_table_top.sv
// parent_sorted_key_table_top: table of DEPTH entries packed at the front and
// ordered by parent key; sequencer around pskt_mem and pskt_cmp.
// Depends on pskt_pkg, pskt_cmp, pskt_mem.
//
//  channel | handshake                | beat contents
//  --------+--------------------------+------------------------------------------
//  in      | i_in_valid / o_in_ready  | i_cmd, i_item_key, i_parent_key, i_payload
//  out     | o_out_valid / i_out_ready| o_status, o_found_key, o_found_parent,
//          |                          | o_found_payload, o_last
//
// Flow: insert is one backward pass that shifts as it compares; search and
// list are one forward scan; delete and remove are one forward scan, then a
// left shift unless the entry found is the last. One entry is read per cycle
// through the single read port of the entry store while the scan is not held;
// the compare unit sees that entry. Errors detected at accept skip the scan.
// Reset: synchronous, active low; clears the sequencer, the fill count and the
// output valid. The table is empty after reset, no clearing pass is needed.
// Stalls: a new beat is taken only when the sequencer is idle; a stalled output
// holds the scan of a list command until the pending beat is taken.
module parent_sorted_key_table_top
    import pskt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [KEY_W-1:0] i_item_key,
    input  logic [KEY_W-1:0] i_parent_key,
    input  logic [KEY_W-1:0] i_payload,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ST_W-1:0]  o_status,
    output logic [KEY_W-1:0] o_found_key,
    output logic [KEY_W-1:0] o_found_parent,
    output logic [KEY_W-1:0] o_found_payload,
    output logic             o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a command beat
    localparam logic [2:0] S_INS   = 3'd1;  // backward pass: compare and shift right
    localparam logic [2:0] S_PUT   = 3'd2;  // write new entry at slot 0
    localparam logic [2:0] S_SCAN  = 3'd3;  // forward scan of occupied slots
    localparam logic [2:0] S_FIN   = 3'd4;  // decide outcome after the scan
    localparam logic [2:0] S_SHIFT = 3'd5;  // left shift after a removal
    localparam logic [2:0] S_RES   = 3'd6;  // hand out the final beat

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_par, n_par;
    logic [KEY_W-1:0] r_pay, n_pay;
    logic             r_hit, n_hit;      // first match found / list beat pending
    logic [AW-1:0]    r_hit_idx, n_hit_idx;
    t_entry           r_hit_ent, n_hit_ent;
    logic             r_child, n_child;
    logic [ST_W-1:0]  r_rstat, n_rstat;

    logic             r_ovld;
    logic [ST_W-1:0]  r_ostat;
    t_entry           r_oent;
    logic             r_olast;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    t_entry           mem_wdata, rd_ent, new_ent;
    t_cmp             flags;

    logic             out_free, emit, e_last;
    logic [ST_W-1:0]  e_stat;
    t_entry           e_ent;
    logic [AW-1:0]    cnt_m1;

    pskt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_ent)
    );

    pskt_cmp u_cmp (
        .i_ent   (rd_ent),
        .i_key   (r_key),
        .i_par   (r_par),
        .o_flags (flags)
    );

    assign out_free = !r_ovld || i_out_ready;
    assign cnt_m1   = AW'(r_count - 1'b1);
    assign new_ent  = '{key: r_key, parent: r_par, payload: r_pay};

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_par     = r_par;
        n_pay     = r_pay;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_hit_ent = r_hit_ent;
        n_child   = r_child;
        n_rstat   = r_rstat;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = rd_ent;
        mem_re    = 1'b0;
        mem_raddr = r_ptr;
        emit      = 1'b0;
        e_stat    = ST_OK;
        e_ent     = r_hit_ent;
        e_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_key   = i_item_key;
                    n_par   = i_parent_key;
                    n_pay   = i_payload;
                    n_hit   = 1'b0;
                    n_child = 1'b0;
                    n_ptr   = '0;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (i_item_key == '0) begin
                                n_rstat = ST_ZERO_KEY;
                                n_state = S_RES;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_rstat = ST_FULL;
                                n_state = S_RES;
                            end else if (r_count == '0) begin
                                n_state = S_PUT;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = cnt_m1;
                                n_ptr     = cnt_m1;
                                n_state   = S_INS;
                            end
                        end
                        CMD_DELETE, CMD_SEARCH, CMD_REMOVE, CMD_LIST: begin
                            if ((i_cmd == CMD_DELETE || i_cmd == CMD_SEARCH)
                                    && i_item_key == '0) begin
                                n_rstat = ST_ZERO_KEY;
                                n_state = S_RES;
                            end else if (r_count == '0) begin
                                n_state = S_FIN;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;   // unused code: no beat
                        end
                    endcase
                end
            end

            S_INS: begin
                if (flags.par_gt) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_ptr + 1'b1);
                    mem_wdata = rd_ent;
                    if (r_ptr == '0) begin
                        n_state = S_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_ptr - 1'b1);
                        n_ptr     = AW'(r_ptr - 1'b1);
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_ptr + 1'b1);
                    mem_wdata = new_ent;
                    n_count   = CW'(r_count + 1'b1);
                    n_hit     = 1'b1;
                    n_hit_ent = new_ent;
                    n_rstat   = ST_OK;
                    n_state   = S_RES;
                end
            end

            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = new_ent;
                n_count   = CW'(r_count + 1'b1);
                n_hit     = 1'b1;
                n_hit_ent = new_ent;
                n_rstat   = ST_OK;
                n_state   = S_RES;
            end

            S_SCAN: begin
                if (r_cmd == CMD_LIST && flags.par_eq && r_hit && !out_free) begin
                    n_state = S_SCAN;   // hold: pending beat cannot leave yet
                end else begin
                    if (r_cmd == CMD_LIST) begin
                        if (flags.par_eq) begin
                            if (r_hit) begin
                                emit   = 1'b1;
                                e_last = 1'b0;
                            end
                            n_hit     = 1'b1;
                            n_hit_ent = rd_ent;
                        end
                    end else begin
                        if (flags.key_eq && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_ptr;
                            n_hit_ent = rd_ent;
                        end
                        if (flags.child) begin
                            n_child = 1'b1;
                        end
                    end
                    if (r_ptr == cnt_m1) begin
                        n_state = S_FIN;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_ptr + 1'b1);
                        n_ptr     = AW'(r_ptr + 1'b1);
                    end
                end
            end

            S_FIN: begin
                n_state = S_RES;
                n_rstat = r_hit ? ST_OK : ST_NOTFOUND;
                if (r_cmd == CMD_REMOVE && r_child) begin
                    n_rstat = ST_HAS_KIDS;
                    n_hit   = 1'b0;
                end else if (r_cmd == CMD_REMOVE && r_key == '0) begin
                    n_rstat = ST_ZERO_KEY;
                    n_hit   = 1'b0;
                end else if ((r_cmd == CMD_DELETE || r_cmd == CMD_REMOVE) && r_hit) begin
                    if (r_hit_idx == cnt_m1) begin
                        n_count = CW'(r_count - 1'b1);
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_hit_idx + 1'b1);
                        n_ptr     = AW'(r_hit_idx + 1'b1);
                        n_state   = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_ptr - 1'b1);
                mem_wdata = rd_ent;
                if (r_ptr == cnt_m1) begin
                    n_count = CW'(r_count - 1'b1);
                    n_state = S_RES;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_ptr + 1'b1);
                    n_ptr     = AW'(r_ptr + 1'b1);
                end
            end

            S_RES: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_stat  = r_rstat;
                    e_ent   = r_hit ? r_hit_ent : '0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_par     <= n_par;
        r_pay     <= n_pay;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_hit_ent <= n_hit_ent;
        r_child   <= n_child;
        r_rstat   <= n_rstat;
        if (emit) begin
            r_ostat <= e_stat;
            r_oent  <= e_ent;
            r_olast <= e_last;
        end
    end

    assign o_out_valid     = r_ovld;
    assign o_status        = r_ostat;
    assign o_found_key     = r_oent.key;
    assign o_found_parent  = r_oent.parent;
    assign o_found_payload = r_oent.payload;
    assign o_last          = r_olast;

    // fill count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above table depth");

    // placing an entry at slot 0 grows the table by exactly one
    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PUT |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("insert at slot 0 did not grow the table");

    // backward insert pass only visits occupied slots
    a_ins_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS |-> {1'b0, r_ptr} < (AW + 1)'(r_count))
        else $error("insert pass outside occupied slots");

    // a beat that is not the last of its command always reports an entry
    a_list_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == ST_OK && o_found_key != '0))
        else $error("non-final beat without a listed entry");

endmodule

### tb/tb.sv
// tb.sv: self-checking bench for parent_sorted_key_table_top; every result beat is
// checked against an in-bench model of the parent-ordered table.
// Depends on pskt_pkg and the RTL of parent_sorted_key_table_top only.
`timescale 1ns / 1ps

module tb
    import pskt_pkg::*;
();

    localparam int DEPTH        = 16;
    localparam int RAND_ITEMS   = 125;   // random command beats, unused codes not counted
    localparam int HOLD_AT      = 60;    // accepted commands before the long output hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_LIMIT   = 4000;  // cycles with no beat on either channel

    typedef struct {
        bit [CMD_W-1:0] cmd;
        bit [KEY_W-1:0] key, parent, payload;
    } t_cmd_beat;

    typedef struct {
        bit [ST_W-1:0]  status;
        bit [KEY_W-1:0] key, parent, payload;
        bit             last;
    } t_resp_beat;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    // DUT ports; the inputs are known from time zero
    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_ready;
    logic [CMD_W-1:0] i_cmd        = '0;
    logic [KEY_W-1:0] i_item_key   = '0;
    logic [KEY_W-1:0] i_parent_key = '0;
    logic [KEY_W-1:0] i_payload    = '0;
    logic             o_out_valid;
    logic             i_out_ready  = 1'b0;
    logic [ST_W-1:0]  o_status;
    logic [KEY_W-1:0] o_found_key;
    logic [KEY_W-1:0] o_found_parent;
    logic [KEY_W-1:0] o_found_payload;
    logic             o_last;

    // mirror of the table contents, packed at the front, ordered by parent
    bit [KEY_W-1:0] tbl_key [DEPTH];
    bit [KEY_W-1:0] tbl_par [DEPTH];
    bit [KEY_W-1:0] tbl_pay [DEPTH];

    t_cmd_beat  cmd_pend_q [$];   // commands not yet offered
    t_resp_beat due_resp_q [$];   // results owed by the block, oldest first
    t_cmd_beat  cur_beat;
    t_resp_beat want;

    int n_errors    = 0;
    int n_cmd_taken = 0;
    int n_ignored   = 0;
    int n_resp      = 0;
    int list_max    = 0;
    int st_seen [8];
    int gap_left    = 0;
    int burst_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int rdy_phase   = 0;
    t_rx_mode rdy_mode = RX_OPEN;
    bit rdy;
    int idle_run    = 0;

    parent_sorted_key_table_top #(.DEPTH(DEPTH)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_item_key     (i_item_key),
        .i_parent_key   (i_parent_key),
        .i_payload      (i_payload),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_found_key    (o_found_key),
        .o_found_parent (o_found_parent),
        .o_found_payload(o_found_payload),
        .o_last         (o_last)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------
    function automatic int find_first(bit [KEY_W-1:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_key[i] != 0 && tbl_key[i] == k) return i;
        return -1;
    endfunction

    // slot < 0: no entry, fields go out as zero
    function automatic void push_resp(bit [ST_W-1:0] st, int slot, bit fin);
        t_resp_beat r;
        r.status = st;
        r.last   = fin;
        if (slot >= 0) begin
            r.key     = tbl_key[slot];
            r.parent  = tbl_par[slot];
            r.payload = tbl_pay[slot];
        end
        due_resp_q.push_back(r);
    endfunction

    // report the entry, then close the hole by shifting left
    function automatic void pull_slot(int idx);
        push_resp(ST_OK, idx, 1'b1);
        for (int i = idx + 1; i < DEPTH; i++) begin
            tbl_key[i-1] = tbl_key[i];
            tbl_par[i-1] = tbl_par[i];
            tbl_pay[i-1] = tbl_pay[i];
        end
        tbl_key[DEPTH-1] = '0;
        tbl_par[DEPTH-1] = '0;
        tbl_pay[DEPTH-1] = '0;
    endfunction

    function automatic void apply_table_cmd(t_cmd_beat b);
        int idx;
        int hits [$];
        idx = 0;
        case (b.cmd)
            CMD_INSERT: begin
                if (b.key == 0) begin
                    push_resp(ST_ZERO_KEY, -1, 1'b1);
                end else if (tbl_key[DEPTH-1] != 0) begin
                    push_resp(ST_FULL, -1, 1'b1);
                end else begin
                    // goes after every entry whose parent is not greater
                    while (idx < DEPTH && tbl_key[idx] != 0 && tbl_par[idx] <= b.parent)
                        idx++;
                    for (int i = DEPTH - 1; i > idx; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_par[i] = tbl_par[i-1];
                        tbl_pay[i] = tbl_pay[i-1];
                    end
                    tbl_key[idx] = b.key;
                    tbl_par[idx] = b.parent;
                    tbl_pay[idx] = b.payload;
                    push_resp(ST_OK, idx, 1'b1);
                end
            end
            CMD_DELETE, CMD_SEARCH: begin
                if (b.key == 0) begin
                    push_resp(ST_ZERO_KEY, -1, 1'b1);
                end else begin
                    idx = find_first(b.key);
                    if (idx < 0) push_resp(ST_NOTFOUND, -1, 1'b1);
                    else if (b.cmd == CMD_SEARCH) push_resp(ST_OK, idx, 1'b1);
                    else pull_slot(idx);
                end
            end
            CMD_REMOVE: begin
                // child check first, so key zero can still report children
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_key[i] != 0 && tbl_par[i] == b.key) hits.push_back(i);
                if (hits.size() != 0) begin
                    push_resp(ST_HAS_KIDS, -1, 1'b1);
                end else if (b.key == 0) begin
                    push_resp(ST_ZERO_KEY, -1, 1'b1);
                end else begin
                    idx = find_first(b.key);
                    if (idx < 0) push_resp(ST_NOTFOUND, -1, 1'b1);
                    else pull_slot(idx);
                end
            end
            CMD_LIST: begin
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_key[i] != 0 && tbl_par[i] == b.parent) hits.push_back(i);
                if (hits.size() == 0) begin
                    push_resp(ST_NOTFOUND, -1, 1'b1);
                end else begin
                    foreach (hits[j]) push_resp(ST_OK, hits[j], j == hits.size() - 1);
                    if (hits.size() > list_max) list_max = hits.size();
                end
            end
            default: n_ignored++;   // unused codes: no result, no change
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_beat(bit [CMD_W-1:0] c, bit [KEY_W-1:0] k,
                                     bit [KEY_W-1:0] p, bit [KEY_W-1:0] d);
        t_cmd_beat b;
        b.cmd     = c;
        b.key     = k;
        b.parent  = p;
        b.payload = d;
        cmd_pend_q.push_back(b);
    endfunction

    // small pool so keys collide and repeat; some zero and full-range values
    function automatic bit [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 15) return $urandom;
        if (r < 18) return '1;
        return $urandom_range(1, 20);
    endfunction

    // parents overlap the key pool so remove sees children
    function automatic bit [KEY_W-1:0] pick_parent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom;
        if (r < 14) return '1;
        return $urandom_range(0, 5);
    endfunction

    function automatic void check_field(string name, bit [KEY_W-1:0] exp_v,
                                        logic [KEY_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: mismatch on %s, expected %h, got %h", $time, name, exp_v, got_v);
            n_errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Command driver: bursts of beats with random gaps in between
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_table_cmd(cur_beat);
                n_cmd_taken++;
            end
            // valid may only move once the current beat is gone
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (cmd_pend_q.size() != 0) begin
                    cur_beat = cmd_pend_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_cmd        <= cur_beat.cmd;
                    i_item_key   <= cur_beat.key;
                    i_parent_key <= cur_beat.parent;
                    i_payload    <= cur_beat.payload;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(0, 8);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: ready follows a random mode that is redrawn when its phase
    // counter runs out; the one long hold-off forces the block to back up its input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_cmd_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (rdy_phase == 0) begin
                rdy_mode  = t_rx_mode'($urandom_range(0, 3));
                rdy_phase = $urandom_range(16, 96);
            end else begin
                rdy_phase--;
            end
            case (rdy_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = ($urandom_range(0, 4) != 0);
            endcase
            i_out_ready <= rdy && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_resp++;
            if (due_resp_q.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got status %0d key %h",
                         $time, o_status, o_found_key);
                n_errors++;
            end else begin
                want = due_resp_q.pop_front();
                check_field("status",  KEY_W'(want.status), KEY_W'(o_status));
                check_field("key",     want.key,     o_found_key);
                check_field("parent",  want.parent,  o_found_parent);
                check_field("payload", want.payload, o_found_payload);
                check_field("last",    KEY_W'(want.last), KEY_W'(o_last));
                st_seen[want.status]++;
            end
        end
    end

    // watchdog: stop a hung run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_run <= 0;
        else idle_run <= idle_run + 1;
        if (idle_run >= IDLE_LIMIT) begin
            $display("[parent_sorted_key_table_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int n_rand;
        int len;
        bit one_par;
        bit [KEY_W-1:0] fix_par;
        bit [CMD_W-1:0] c;
        n_rand = 0;

        // empty table: zero keys and misses on every command
        add_beat(CMD_INSERT, '0, 32'd1, 32'h1234_5678);
        add_beat(CMD_SEARCH, '0, '0, '0);
        add_beat(CMD_DELETE, '0, '0, '0);
        add_beat(CMD_REMOVE, '0, '0, '0);          // no children, so zero key
        add_beat(CMD_LIST,   32'd5, '0, '0);       // no match: one beat, not found
        add_beat(CMD_SEARCH, 32'd5, '0, '0);
        add_beat(CMD_DELETE, 32'd5, '0, '0);
        add_beat(CMD_REMOVE, 32'd5, '0, '0);
        // extremes, equal parents, duplicate key
        add_beat(CMD_INSERT, '1, '1, '1);
        add_beat(CMD_INSERT, 32'd1, '0, '0);
        add_beat(CMD_INSERT, 32'd2, 32'd1, 32'hA5A5_A5A5);
        add_beat(CMD_INSERT, 32'd3, 32'd1, 32'h5A5A_5A5A);
        add_beat(CMD_INSERT, 32'd3, '0, 32'hDEAD_BEEF);
        add_beat(CMD_SEARCH, 32'd3, '0, '0);       // first of the two
        add_beat(CMD_LIST,   '0, 32'd1, '0);       // two beats, last on the second
        add_beat(CMD_REMOVE, 32'd1, '0, '0);       // has children
        add_beat(CMD_REMOVE, '0, '0, '0);          // key zero but parent-zero entries exist
        add_beat(CMD_DELETE, 32'd3, '0, '0);
        add_beat(CMD_REMOVE, 32'd2, '0, '0);
        add_beat(CMD_LIST,   '0, '1, '0);
        add_beat(3'd5, '1, '1, '1);                // unused codes
        add_beat(3'd6, '0, '0, '0);
        add_beat(3'd7, 32'd1, 32'd1, 32'd1);

        while (n_rand < RAND_ITEMS) begin
            case ($urandom_range(0, 3))
                0: begin
                    // fill run, often under one parent so the list gets long
                    len     = $urandom_range(6, 20);
                    one_par = $urandom_range(0, 1);
                    fix_par = pick_parent();
                    repeat (len)
                        add_beat(CMD_INSERT, pick_key(), one_par ? fix_par : pick_parent(),
                                 $urandom);
                    add_beat(CMD_LIST, pick_key(), fix_par, $urandom);
                    n_rand += len + 1;
                end
                1: begin
                    repeat (12) begin
                        add_beat(CMD_W'($urandom_range(0, 4)), pick_key(), pick_parent(),
                                 $urandom);
                        if ($urandom_range(0, 15) == 0)
                            add_beat(CMD_W'($urandom_range(5, 7)), $urandom, $urandom,
                                     $urandom);
                    end
                    n_rand += 12;
                end
                2: begin
                    repeat (10) begin
                        case ($urandom_range(0, 2))
                            0:       c = CMD_DELETE;
                            1:       c = CMD_REMOVE;
                            default: c = CMD_SEARCH;
                        endcase
                        add_beat(c, pick_key(), pick_parent(), $urandom);
                    end
                    n_rand += 10;
                end
                default: begin
                    repeat (8)
                        add_beat($urandom_range(0, 1) ? CMD_LIST : CMD_SEARCH, pick_key(),
                                 pick_parent(), $urandom);
                    n_rand += 8;
                end
            endcase
        end

        // sample between edges so the driver's updates have settled
        wait (i_rst_n);
        while (cmd_pend_q.size() != 0 || i_in_valid) @(negedge i_clk);
        while (due_resp_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands (%0d with unused codes), %0d result beats, longest list %0d",
                 n_cmd_taken, n_ignored, n_resp, list_max);
        $display("statuses seen: ok %0d, zero key %0d, full %0d, not found %0d, has children %0d",
                 st_seen[ST_OK], st_seen[ST_ZERO_KEY], st_seen[ST_FULL], st_seen[ST_NOTFOUND],
                 st_seen[ST_HAS_KIDS]);
        if (n_errors == 0 && due_resp_q.size() == 0) begin
            $display("[parent_sorted_key_table_top] OK");
        end else begin
            $display("[parent_sorted_key_table_top] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/pskt_pkg.sv
rtl/pskt_cmp.sv
rtl/pskt_mem.sv
rtl/parent_sorted_key_table_top.sv
tb/tb.sv
